[rtl/core/olief_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_pkg
// Shared types and codes for the ordered list block: the data width,
// operation and status codes, sequencer states and the memory control group.
// ----------------------------------------------------------------------------
package olief_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6,
        OP_DUMP       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_USE  = 3'b100
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

[rtl/core/ordered_list_insert_erase_find.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_find
// Bounded ordered list of signed words with push, pop, insert, erase, find
// and dump, built on a single-port-read element memory and a sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start, accepted when !busy operation, position, value
//  result    done, one-cycle strobe     status, found, element, count, last
//
//  push back, pop back and any refused request: result in the cycle after accept.
//  shifts, find and dump take a read state and a use state per element moved,
//  compared or emitted, as the element memory has a registered read; a dump gives
//  one result per element. busy is high from accept until the final result.
//  reset clears the count; memory contents are only read below the count.
//  results cannot be stalled; the block accepts nothing while busy.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_find #(
    parameter int CAPACITY = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  olief_pkg::op_t                              operation,
    input  logic [$clog2(CAPACITY+1)-1:0]               position,
    input  logic signed [olief_pkg::DATA_W-1:0]         value,
    output logic                                        busy,
    output logic                                        done,
    output olief_pkg::status_t                          status,
    output logic                                        found,
    output logic signed [olief_pkg::DATA_W-1:0]         element,
    output logic [$clog2(CAPACITY+1)-1:0]               count,
    output logic                                        last
);
    import olief_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] element_bits;

    olief_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .position  (position),
        .value     (value),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .found     (found),
        .element   (element_bits),
        .count     (count),
        .last      (last),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    olief_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign element = signed'(element_bits);

endmodule

[rtl/core/olief_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_mem
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olief_mem #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4
) (
    input  logic                           clk,
    input  olief_pkg::mem_ctl_t            ctl,
    input  logic [AW-1:0]                  waddr,
    input  logic [olief_pkg::DATA_W-1:0]   wdata,
    input  logic [AW-1:0]                  raddr,
    output logic [olief_pkg::DATA_W-1:0]   rdata
);
    import olief_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/olief_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_ctrl
// Sequencer for the list operations. An up and a down index stepper are reused
// each step to shift, search and dump elements; one equality comparator serves the search.
// ----------------------------------------------------------------------------
module olief_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5,
    parameter int AW       = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  olief_pkg::op_t                 operation,
    input  logic [CNT_W-1:0]               position,
    input  logic [olief_pkg::DATA_W-1:0]   value,
    output logic                           busy,
    output logic                           done,
    output olief_pkg::status_t             status,
    output logic                           found,
    output logic [olief_pkg::DATA_W-1:0]   element,
    output logic [CNT_W-1:0]               count,
    output logic                           last,
    output olief_pkg::mem_ctl_t            mem_ctl,
    output logic [AW-1:0]                  mem_waddr,
    output logic [olief_pkg::DATA_W-1:0]   mem_wdata,
    output logic [AW-1:0]                  mem_raddr,
    input  logic [olief_pkg::DATA_W-1:0]   mem_rdata
);
    import olief_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    state_t            state_reg,   state_next;
    op_t               op_reg,      op_next;
    logic [CNT_W-1:0]  idx_reg,     idx_next;
    logic [CNT_W-1:0]  pos_reg,     pos_next;
    logic [DATA_W-1:0] value_reg,   value_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              done_reg,    done_next;
    status_t           status_reg,  status_next;
    logic              found_reg,   found_next;
    logic [DATA_W-1:0] element_reg, element_next;
    logic              last_reg,    last_next;

    // shared step unit
    logic [CNT_W-1:0] idx_up;
    logic [CNT_W-1:0] idx_dn;
    logic             match;

    assign idx_up = idx_reg + 1'b1;
    assign idx_dn = idx_reg - 1'b1;
    assign match  = (mem_rdata == value_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        element_next = element_reg;
        last_next    = last_reg;
        mem_ctl      = '0;
        mem_waddr    = idx_reg[AW-1:0];
        mem_wdata    = mem_rdata;
        mem_raddr    = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = operation;
                    value_next   = value;
                    status_next  = ST_OK;
                    found_next   = 1'b0;
                    element_next = '0;
                    last_next    = 1'b1;
                    unique case (operation)
                        OP_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= CAP)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                mem_waddr     = count_reg[AW-1:0];
                                mem_wdata     = value;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (count_reg >= CAP)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                pos_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_INSERT:
                        begin
                            // position is checked before fullness
                            if (position > count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADPOS;
                            end
                            else if (count_reg >= CAP)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                pos_next   = position;
                                state_next = S_SCAN;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (position >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = position;
                                state_next = S_SCAN;
                            end
                        end
                        OP_FIND:
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                case (op_reg) inside
                    OP_PUSH_FRONT, OP_INSERT:
                    begin
                        // open the gap from the top down, then drop the value in
                        if (idx_reg > pos_reg)
                        begin
                            mem_ctl.rd_en = 1'b1;
                            mem_raddr     = idx_dn[AW-1:0];
                            state_next    = S_USE;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_waddr     = pos_reg[AW-1:0];
                            mem_wdata     = value_reg;
                            count_next    = count_reg + 1'b1;
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    OP_POP_FRONT, OP_ERASE:
                    begin
                        if (idx_up < count_reg)
                        begin
                            mem_ctl.rd_en = 1'b1;
                            mem_raddr     = idx_up[AW-1:0];
                            state_next    = S_USE;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // find and dump walk up from the bottom
                        if (idx_reg < count_reg)
                        begin
                            mem_ctl.rd_en = 1'b1;
                            mem_raddr     = idx_reg[AW-1:0];
                            state_next    = S_USE;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_USE:
            begin
                case (op_reg) inside
                    OP_PUSH_FRONT, OP_INSERT:
                    begin
                        mem_ctl.wr_en = 1'b1;
                        idx_next      = idx_dn;
                        state_next    = S_SCAN;
                    end
                    OP_POP_FRONT, OP_ERASE:
                    begin
                        mem_ctl.wr_en = 1'b1;
                        idx_next      = idx_up;
                        state_next    = S_SCAN;
                    end
                    OP_FIND:
                    begin
                        if (match)
                        begin
                            found_next = 1'b1;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_up;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        done_next    = 1'b1;
                        element_next = mem_rdata;
                        last_next    = (idx_up == count_reg);
                        idx_next     = idx_up;
                        state_next   = (idx_up == count_reg) ? S_IDLE : S_SCAN;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign status  = status_reg;
    assign found   = found_reg;
    assign element = element_reg;
    assign count   = count_reg;
    assign last    = last_reg;

endmodule

[rtl/core/olief_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_chk
// Port-level checks for the ordered list block, bound to the top level.
// ----------------------------------------------------------------------------
module olief_chk #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  olief_pkg::status_t                  status,
    input  logic                                found,
    input  logic [olief_pkg::DATA_W-1:0]        element,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    input  logic                                last
);
    import olief_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // every accepted request either starts work or answers at once
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("request accepted but neither busy nor answered");

    // the final result closes the request
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> !busy)
        else $error("busy still high on final result");

    // a dump in progress keeps the block busy between elements
    a_mid_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy && status == ST_OK)
        else $error("intermediate result while idle or not ok");

    // refused requests carry no element or find flag
    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> element == '0 && !found && last)
        else $error("refused request with payload");

    // occupancy never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

endmodule

bind ordered_list_insert_erase_find olief_chk #(
    .CAPACITY (CAPACITY)
) u_olief_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .status  (status),
    .found   (found),
    .element (element),
    .count   (count),
    .last    (last)
);
